// ----- sv/audio_flanger_unit_macros.svh -----
// Assertion macros shared by the flanger RTL.
`ifndef AUDIO_FLANGER_UNIT_MACROS_SVH
`define AUDIO_FLANGER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define AFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define AFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/afu_pkg.sv -----
// Types, constants and sine table of the flanger.
package afu_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = 25;
  localparam int SUM_BITS    = 28;

  localparam int BASE_BITS   = 12;
  localparam int ATT_BITS    = 8;
  localparam int PERIOD_BITS = 17;
  localparam int DEPTH_BITS  = 12;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_DELAY  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ATT_DIV     = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MOD_PERIOD  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWING       = 8'd3;

  localparam logic [BASE_BITS-1:0]   BASE_DELAY_RST  = 12'd480;
  localparam logic [ATT_BITS-1:0]    ATTENUATION_RST = 8'd40;
  localparam logic [PERIOD_BITS-1:0] MOD_PERIOD_RST  = 17'd48000;
  localparam logic [DEPTH_BITS-1:0]  MOD_DEPTH_RST   = 12'd240;

  // Sine table: Q1.15, one full period
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AW      = 10;
  localparam int ROM_BITS     = 16;
  localparam int MAG_BITS     = 15;

  // Shared restoring divider: remainder as wide as the period, 27-bit quotient shifter
  localparam int QUO_BITS  = 27;
  localparam int MUL_BITS  = MAG_BITS + DEPTH_BITS;
  localparam int STEP_BITS = 5;
  localparam int IDX_STEPS = SINE_AW;
  localparam int MUL_STEPS = DEPTH_BITS;
  localparam int ATT_STEPS = QUO_BITS;

  // Minimum width of base + swing, before the clamp
  localparam int TAP_SUM_BITS = 14;

  localparam logic signed [SUM_BITS-1:0] OUT_MAX = 28'sd16777215;
  localparam logic signed [SUM_BITS-1:0] OUT_MIN = -28'sd16777216;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef logic [SINE_ENTRIES-1:0][ROM_BITS-1:0] sine_rom_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX_DIV,
    ST_ROM,
    ST_MUL,
    ST_TAP,
    ST_ADDR,
    ST_FETCH,
    ST_ATT_DIV,
    ST_DONE
  } afu_state_t;

  // Quarter-wave folded Taylor series in Q30, rounded to Q15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned a, quad, rem, t, x, x2, acc, s, q;
    int k;
    rom = '0;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      a    = 64'(4 * i);
      quad = a / SINE_ENTRIES;
      rem  = a % SINE_ENTRIES;
      t    = quad[0] ? (64'(SINE_ENTRIES) - rem) : rem;
      x    = PI_HALF_Q30 * t / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      acc  = ONE_Q30;
      for (k = 10; k >= 2; k -= 2)
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'(k * (k + 1));
      s = (x * acc) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 64'd32767)
        q = 64'd32767;
      rom[i] = (quad >= 64'd2) ? ROM_BITS'(-q) : ROM_BITS'(q);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- sv/audio_flanger_unit.sv -----
// Flanger top level: delay line, modulation sequencer and bit-serial arithmetic.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   in       | to block  | in_valid/in_stall  | in_sample_in   (24b signed)
//   out      | from block| out_valid/out_stall| out_sample_out (25b signed)
//   cfg      | to block  | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// An item passes from accept to result through 10 divider steps for the sine index,
// 12 multiplier steps, 27 divider steps for the attenuation, and one state each for
// table read, tap, address, fetch and output; a new item is accepted only in idle.
// The result waits in an output register; the next item is taken meanwhile and holds
// in its output cycle while an earlier result is still stalled.
// No clearing pass after reset: a fill flag marks unwritten delay entries as zero.
`include "audio_flanger_unit_macros.svh"

module audio_flanger_unit
  import afu_pkg::*;
#(
  parameter int DELAY_LENGTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [OUT_BITS-1:0]       out_sample_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic        [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int AW = $clog2(DELAY_LENGTH);
  localparam int DW = (AW + 1 > TAP_SUM_BITS) ? AW + 1 : TAP_SUM_BITS;
  localparam logic signed [DW-1:0] TAP_MAX = DW'(DELAY_LENGTH - 1);
  localparam logic [AW-1:0] WP_LAST = AW'(DELAY_LENGTH - 1);

  // configuration
  logic [BASE_BITS-1:0]   base_delay_r;
  logic [ATT_BITS-1:0]    attenuation_r;
  logic [PERIOD_BITS-1:0] mod_period_r;
  logic [DEPTH_BITS-1:0]  mod_depth_r;

  // control
  afu_state_t             state_r, state_nxt;
  logic [PERIOD_BITS-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic                   wrapped_r, wrapped_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // datapath
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [PERIOD_BITS-1:0]        rem_r, rem_nxt;
  logic [PERIOD_BITS-1:0]        div_r, div_nxt;
  logic [QUO_BITS-1:0]           quo_r, quo_nxt;
  logic [MUL_BITS-1:0]           mul_r, mul_nxt;
  logic [AW-1:0]                 off_r, off_nxt;
  logic                          tap_zero_r, tap_zero_nxt;
  logic                          tap_valid_r, tap_valid_nxt;
  logic                          neg_r, neg_nxt;
  logic signed [OUT_BITS-1:0]    out_sample_r, out_sample_nxt;
  logic signed [ROM_BITS-1:0]    rom_q_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;

  logic signed [SAMPLE_BITS-1:0] delay_mem [DELAY_LENGTH];

  logic                   in_accept;
  logic                   mem_we, mem_re, rom_re;
  logic [SINE_AW-1:0]     rom_idx;
  logic [AW-1:0]          rd_addr;
  logic [AW:0]            rd_diff;
  logic [PERIOD_BITS-1:0] cnt_plus, cnt_inc;

  // divider step
  logic [PERIOD_BITS:0]   div_trial, div_diff;
  logic                   div_ge;

  // multiplier step
  logic [MAG_BITS-1:0]    rom_mag;
  logic [MAG_BITS:0]      mul_sum;

  // tap
  logic [DEPTH_BITS-1:0]  mod_mag;
  logic signed [DW-1:0]   base_ext, mod_ext, d_sum;

  // fetch and output
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic [SAMPLE_BITS-1:0]        delayed_mag;
  logic signed [SUM_BITS-1:0]    term, y_sum;

  // checks
  logic                   div_busy;
  logic                   cnt_in_range;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign cnt_plus = cnt_r + 1'b1;
  assign cnt_inc  = (cnt_plus >= mod_period_r) ? '0 : cnt_plus;

  // restoring division, one quotient bit per cycle
  assign div_trial = {rem_r, quo_r[QUO_BITS-1]};
  assign div_diff  = div_trial - {1'b0, div_r};
  assign div_ge    = (div_trial >= {1'b0, div_r});

  // shift-add multiply, one depth bit per cycle, LSB first
  assign rom_mag = rom_q_r[ROM_BITS-1] ? MAG_BITS'(-rom_q_r) : MAG_BITS'(rom_q_r);
  assign mul_sum = {1'b0, mul_r[MUL_BITS-1:DEPTH_BITS]} +
                   (mul_r[0] ? {1'b0, rom_mag} : '0);

  assign rom_idx = (mod_period_r == '0) ? '0 : quo_r[SINE_AW-1:0];

  assign mod_mag  = mul_r[MUL_BITS-1:MAG_BITS];
  assign base_ext = $signed({{(DW-BASE_BITS){1'b0}}, base_delay_r});
  assign mod_ext  = $signed({{(DW-DEPTH_BITS){1'b0}}, mod_mag});
  assign d_sum    = rom_q_r[ROM_BITS-1] ? (base_ext - mod_ext) : (base_ext + mod_ext);

  assign rd_diff = {1'b0, wp_r} - {1'b0, off_r};
  assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(DELAY_LENGTH)) : rd_diff[AW-1:0];

  // offset zero is the sample just written; entries not yet written read as zero
  assign delayed     = tap_zero_r ? sample_r : (tap_valid_r ? rd_data_r : '0);
  assign delayed_mag = delayed[SAMPLE_BITS-1] ? SAMPLE_BITS'(-delayed)
                                              : SAMPLE_BITS'(delayed);

  assign term  = (attenuation_r == '0) ? '0 :
                 (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}));
  assign y_sum = SUM_BITS'(sample_r) + term;

  assign div_busy     = (state_r == ST_IDX_DIV || state_r == ST_ATT_DIV) && (div_r != '0);
  assign cnt_in_range = (cnt_r < mod_period_r) || (cnt_r == '0);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    wp_nxt         = wp_r;
    wrapped_nxt    = wrapped_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && out_stall;
    sample_nxt     = sample_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    mul_nxt        = mul_r;
    off_nxt        = off_r;
    tap_zero_nxt   = tap_zero_r;
    tap_valid_nxt  = tap_valid_r;
    neg_nxt        = neg_r;
    out_sample_nxt = out_sample_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rom_re         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          mem_we     = 1'b1;
          sample_nxt = in_sample_in;
          cnt_nxt    = cnt_inc;
          // index = cnt * 1024 / period: start with cnt as remainder, shift in zeros
          rem_nxt    = cnt_inc;
          quo_nxt    = '0;
          div_nxt    = mod_period_r;
          step_nxt   = STEP_BITS'(IDX_STEPS - 1);
          state_nxt  = ST_IDX_DIV;
        end
      end
      ST_IDX_DIV, ST_ATT_DIV: begin
        rem_nxt  = div_ge ? div_diff[PERIOD_BITS-1:0] : div_trial[PERIOD_BITS-1:0];
        quo_nxt  = {quo_r[QUO_BITS-2:0], div_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0)
          state_nxt = (state_r == ST_IDX_DIV) ? ST_ROM : ST_DONE;
      end
      ST_ROM: begin
        rom_re    = 1'b1;
        mul_nxt   = {{MAG_BITS{1'b0}}, mod_depth_r};
        step_nxt  = STEP_BITS'(MUL_STEPS - 1);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mul_nxt  = {mul_sum, mul_r[DEPTH_BITS-1:1]};
        step_nxt = step_r - 1'b1;
        if (step_r == '0)
          state_nxt = ST_TAP;
      end
      ST_TAP: begin
        if (d_sum < 0)
          off_nxt = '0;
        else if (d_sum > TAP_MAX)
          off_nxt = WP_LAST;
        else
          off_nxt = d_sum[AW-1:0];
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        mem_re        = 1'b1;
        tap_zero_nxt  = (off_r == '0);
        tap_valid_nxt = wrapped_r || (rd_addr < wp_r);
        state_nxt     = ST_FETCH;
      end
      ST_FETCH: begin
        rem_nxt   = '0;
        quo_nxt   = {delayed_mag, 3'b000};
        div_nxt   = {{(PERIOD_BITS-ATT_BITS){1'b0}}, attenuation_r};
        neg_nxt   = delayed[SAMPLE_BITS-1];
        step_nxt  = STEP_BITS'(ATT_STEPS - 1);
        state_nxt = ST_ATT_DIV;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (y_sum > OUT_MAX)
            out_sample_nxt = OUT_MAX[OUT_BITS-1:0];
          else if (y_sum < OUT_MIN)
            out_sample_nxt = OUT_MIN[OUT_BITS-1:0];
          else
            out_sample_nxt = y_sum[OUT_BITS-1:0];
          out_valid_nxt = 1'b1;
          if (wp_r == WP_LAST) begin
            wp_nxt      = '0;
            wrapped_nxt = 1'b1;
          end else begin
            wp_nxt = wp_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      wp_r          <= '0;
      wrapped_r     <= 1'b0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
      base_delay_r  <= BASE_DELAY_RST;
      attenuation_r <= ATTENUATION_RST;
      mod_period_r  <= MOD_PERIOD_RST;
      mod_depth_r   <= MOD_DEPTH_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_DELAY:  base_delay_r  <= cfg_wdata[BASE_BITS-1:0];
          CFG_ATT_DIV:     attenuation_r <= cfg_wdata[ATT_BITS-1:0];
          CFG_MOD_PERIOD:  mod_period_r  <= cfg_wdata[PERIOD_BITS-1:0];
          CFG_SWING:       mod_depth_r   <= cfg_wdata[DEPTH_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    mul_r        <= mul_nxt;
    off_r        <= off_nxt;
    tap_zero_r   <= tap_zero_nxt;
    tap_valid_r  <= tap_valid_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (rom_re)
      rom_q_r <= $signed(SINE_ROM[rom_idx]);
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      delay_mem[wp_r] <= in_sample_in;
    if (mem_re)
      rd_data_r <= delay_mem[rd_addr];
  end

  `AFU_ASSERT_NOW(a_div_rem_bound, div_busy, rem_r < div_r, "divider remainder not below divisor")
  `AFU_ASSERT_NEXT(a_cnt_in_period, in_accept, cnt_in_range, "modulation counter beyond period")
  `AFU_ASSERT_NOW(a_out_wp_step, $rose(out_valid_r), wp_r != $past(wp_r), "wp did not advance")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the flanger: item-level predictor and scoreboard.
module tb_top
  import afu_pkg::*;
();

  localparam int DELAY_LEN = 4096;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned UNIT_Q30    = 64'd1073741824;
  localparam longint SAT_HI = 64'sd16777215;
  localparam longint SAT_LO = -64'sd16777216;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_UNUSED = CFG_SWING + 1'b1;
  localparam int SETTLE_CYCLES = 64;
  localparam int RAND_CHUNKS   = 12;
  localparam int CHUNK_ITEMS   = 98;
  localparam int MAX_REPORTS   = 40;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [SAMPLE_BITS-1:0]    in_sample_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [OUT_BITS-1:0]       out_sample_out;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic        [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic        [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] delay_mem [DELAY_LEN];
  logic [11:0]                   wr_ptr;
  logic [PERIOD_BITS-1:0]        mod_cnt;
  int                            sine_tab [SINE_ENTRIES];
  logic [BASE_BITS-1:0]          base_delay_r;
  logic [ATT_BITS-1:0]           att_r;
  logic [PERIOD_BITS-1:0]        period_r;
  logic [DEPTH_BITS-1:0]         depth_r;

  logic signed [SAMPLE_BITS-1:0] pending_q [$];
  logic signed [OUT_BITS-1:0]    expected_q [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_cnt  = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_cfg     = 0;

  audio_flanger_unit #(.DELAY_LENGTH(DELAY_LEN)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Quarter-wave folded polynomial sine, Q1.15
  function automatic int q15_sine(input int i);
    longint unsigned a, quad, rem, t, x, x2, acc, s, q;
    int k;
    a    = 64'(4 * i);
    quad = a / SINE_ENTRIES;
    rem  = a % SINE_ENTRIES;
    t    = quad[0] ? (SINE_ENTRIES - rem) : rem;
    x    = HALF_PI_Q30 * t / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    acc  = UNIT_Q30;
    for (k = 10; k >= 2; k -= 2)
      acc = UNIT_Q30 - ((x2 * acc) >> 30) / longint'(k * (k + 1));
    s = (x * acc) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767)
      q = 64'd32767;
    return (quad >= 2) ? -int'(q) : int'(q);
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_BASE_DELAY:  base_delay_r = data[BASE_BITS-1:0];
      CFG_ATT_DIV:     att_r        = data[ATT_BITS-1:0];
      CFG_MOD_PERIOD:  period_r     = data[PERIOD_BITS-1:0];
      CFG_SWING:       depth_r      = data[DEPTH_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Writes one sample into the delay line and returns the flanged output.
  function automatic logic signed [OUT_BITS-1:0] flange_sample(
      input logic signed [SAMPLE_BITS-1:0] smp);
    longint x, prod, swing, tap, dly, term, y;
    int     sidx, rd;
    x = smp;
    delay_mem[wr_ptr] = smp;
    mod_cnt = mod_cnt + 1'b1;
    if (mod_cnt >= period_r)
      mod_cnt = '0;
    sidx = 0;
    if (period_r != 0)
      sidx = int'(longint'(mod_cnt) * SINE_ENTRIES / longint'(period_r));
    if (sidx >= SINE_ENTRIES)
      sidx = SINE_ENTRIES - 1;
    prod  = longint'(sine_tab[sidx]) * longint'(depth_r);
    swing = (prod < 0) ? -((-prod) >> 15) : (prod >> 15);
    tap   = longint'(base_delay_r) + swing;
    if (tap < 0)
      tap = 0;
    if (tap > DELAY_LEN - 1)
      tap = DELAY_LEN - 1;
    rd  = int'((longint'(wr_ptr) + DELAY_LEN - tap) % DELAY_LEN);
    dly = delay_mem[rd];
    term = 0;
    if (att_r != 0)
      term = (8 * dly) / longint'(att_r);
    y = x + term;
    if (y > SAT_HI)
      y = SAT_HI;
    if (y < SAT_LO)
      y = SAT_LO;
    wr_ptr = wr_ptr + 1'b1;
    return OUT_BITS'(y);
  endfunction

  // driver: predicts on acceptance, holds a stalled item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_sample_in <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(flange_sample(in_sample_in));
      if (in_valid && in_stall) begin
      end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_sample_in <= pending_q.pop_front();
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("unexpected item: sample_out actual %0d", out_sample_out);
        end else begin
          logic signed [OUT_BITS-1:0] want;
          want = expected_q.pop_front();
          n_checked++;
          if (out_sample_out !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $error("sample_out mismatch: expected %0d, actual %0d", want, out_sample_out);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input int base, input int att, input int period, input int depth);
    cfg_write(CFG_BASE_DELAY, base);
    cfg_write(CFG_ATT_DIV, att);
    cfg_write(CFG_MOD_PERIOD, period);
    cfg_write(CFG_SWING, depth);
  endtask

  // extremes, zero, one, or random, with junk above the register width now and then
  function automatic logic [CFG_DATA_BITS-1:0] reg_value(input int bits);
    logic [CFG_DATA_BITS-1:0] mask, v;
    mask = (32'd1 << bits) - 1;
    case ($urandom_range(4))
      0:       v = '0;
      1:       v = mask;
      2:       v = 1;
      default: v = $urandom & mask;
    endcase
    if ($urandom_range(3) == 0)
      v |= $urandom & ~mask;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return SAMPLE_BITS'($signed($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_BITS-1:0] period_val;
    foreach (delay_mem[i]) delay_mem[i] = '0;
    foreach (sine_tab[i]) sine_tab[i] = q15_sine(i);
    wr_ptr       = '0;
    mod_cnt      = '0;
    base_delay_r = BASE_DELAY_RST;
    att_r        = ATTENUATION_RST;
    period_r     = MOD_PERIOD_RST;
    depth_r      = MOD_DEPTH_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, empty delay line
    @(negedge clk);
    pending_q = '{SMP_MAX, SMP_MIN, 0, -1};
    settle();

    // tap on the current sample, full gain: both output rails
    set_regs(0, 1, 1, 0);
    @(negedge clk);
    pending_q = '{SMP_MAX, SMP_MIN, 1, -1};
    settle();

    // zero period and zero attenuation; unmapped indexes must be ignored
    set_regs(4095, 0, 0, 4095);
    cfg_write(CFG_INDEX_BITS'($urandom_range(255, CFG_FIRST_UNUSED)), $urandom);
    cfg_write(8'hFF, $urandom);
    @(negedge clk);
    pending_q = '{SMP_MAX, SMP_MIN, 5};
    settle();

    // swing pushes the tap past the top, then below zero
    set_regs(4095, 1, 4, 4095);
    @(negedge clk);
    pending_q = '{SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN};
    settle();
    cfg_write(CFG_BASE_DELAY, 32'hFFFF_F001);
    @(negedge clk);
    pending_q = '{SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX};
    settle();

    // lowering the period below the running counter
    set_regs(2, 255, 131071, 100);
    @(negedge clk);
    pending_q = '{100, -100, 1000, -1000};
    settle();
    cfg_write(CFG_MOD_PERIOD, 2);
    @(negedge clk);
    pending_q = '{7, -7, 8};
    settle();

    for (int c = 0; c < RAND_CHUNKS; c++) begin
      // short periods sweep the whole sine table
      period_val = ($urandom_range(1) == 0) ? $urandom_range(300, 1) : reg_value(PERIOD_BITS);
      cfg_write(CFG_BASE_DELAY, reg_value(BASE_BITS));
      cfg_write(CFG_ATT_DIV, reg_value(ATT_BITS));
      cfg_write(CFG_MOD_PERIOD, period_val);
      cfg_write(CFG_SWING, reg_value(DEPTH_BITS));
      if ($urandom_range(3) == 0)
        cfg_write(CFG_INDEX_BITS'($urandom_range(255, CFG_FIRST_UNUSED)), $urandom);
      @(negedge clk);
      case (c % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < CHUNK_ITEMS; n++)
        pending_q.push_back(rand_sample());
      settle();
    end

    $display("Run covered %0d samples, %0d checked results, %0d register writes,",
             n_sent, n_checked, n_cfg);
    $display("tap clamping, saturation, zero period and attenuation, idle and stall phases.");
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
